/* rtl/smwp_pkg.sv */
// ----------------------------------------------------------------------------
// smwp_pkg
// Shared types and codes for the serial memory write command parser.
// ----------------------------------------------------------------------------
package smwp_pkg;

  // command bytes
  localparam logic [7:0] CMD_BIT_SET  = 8'd190;
  localparam logic [7:0] CMD_BIT_CLR  = 8'd191;
  localparam logic [7:0] CMD_BIT_INV  = 8'd192;
  localparam logic [7:0] CMD_TABLE_WR = 8'd251;

  // progress codes
  localparam logic [1:0] PROG_IDLE  = 2'd0;
  localparam logic [1:0] PROG_ARMED = 2'd1;
  localparam logic [1:0] PROG_CMD   = 2'd2;
  localparam logic [1:0] PROG_DONE  = 2'd3;

  // write kinds
  localparam logic [1:0] KIND_TABLE = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_CLR   = 2'd2;
  localparam logic [1:0] KIND_INV   = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       break_seen;
  } item_t;

  typedef struct packed {
    logic [1:0]  progress;
    logic        write_valid;
    logic [1:0]  write_kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
  } result_t;

endpackage

/* rtl/smwp_decoder.sv */
// ----------------------------------------------------------------------------
// smwp_decoder
// Frame state and decode: one received byte in, one result out per step.
// ----------------------------------------------------------------------------
module smwp_decoder
  import smwp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  output result_t result
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CMD   = 3'd1,
    PH_INDEX = 3'd2,
    PH_THIRD = 3'd3,
    PH_SET   = 3'd4,
    PH_CLR   = 3'd5,
    PH_INV   = 3'd6
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] command_code, command_code_next;
  logic [7:0] index_low, index_low_next;
  logic [7:0] index_high, index_high_next;
  logic [15:0] addr16;

  assign addr16 = {index_high, index_low};

  always_comb begin
    phase_next        = phase;
    command_code_next = command_code;
    index_low_next    = index_low;
    index_high_next   = index_high;
    result            = '0;
    if (item.break_seen) begin
      phase_next      = PH_CMD;
      result.progress = PROG_ARMED;
    end else begin
      unique case (phase)
        PH_CMD: begin
          command_code_next = item.rx_byte;
          phase_next        = PH_INDEX;
          result.progress   = PROG_CMD;
        end
        PH_INDEX: begin
          index_low_next  = item.rx_byte;
          phase_next      = PH_THIRD;
          result.progress = PROG_DONE;
        end
        PH_THIRD: begin
          phase_next      = PH_IDLE;
          result.progress = PROG_DONE;
          priority case (command_code)
            CMD_BIT_SET: begin
              index_high_next = item.rx_byte;
              phase_next      = PH_SET;
            end
            CMD_BIT_CLR: begin
              index_high_next = item.rx_byte;
              phase_next      = PH_CLR;
            end
            CMD_BIT_INV: begin
              index_high_next = item.rx_byte;
              phase_next      = PH_INV;
            end
            CMD_TABLE_WR: begin
              result.write_valid   = 1'b1;
              result.write_kind    = KIND_TABLE;
              result.write_address = {8'd0, index_low};
              result.write_data    = item.rx_byte;
            end
            default: ;
          endcase
        end
        PH_SET, PH_CLR, PH_INV: begin
          phase_next           = PH_IDLE;
          result.progress      = PROG_DONE;
          result.write_valid   = 1'b1;
          result.write_address = addr16;
          result.write_data    = item.rx_byte;
          unique case (phase)
            PH_SET:  result.write_kind = KIND_SET;
            PH_CLR:  result.write_kind = KIND_CLR;
            default: result.write_kind = KIND_INV;
          endcase
        end
        default: begin
          // idle and the unused code
          phase_next      = PH_IDLE;
          result.progress = PROG_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      command_code <= '0;
      index_low    <= '0;
      index_high   <= '0;
    end else if (step) begin
      phase        <= phase_next;
      command_code <= command_code_next;
      index_low    <= index_low_next;
      index_high   <= index_high_next;
    end
  end

endmodule

/* rtl/serial_memory_write_command_parser.sv */
// ----------------------------------------------------------------------------
// serial_memory_write_command_parser
// Decodes break-delimited serial frames into memory write requests.
// ----------------------------------------------------------------------------
// Input channel item/item_valid/item_ready carries one received byte and its
// line-break flag per transfer. Output channel result/result_valid/
// result_ready carries exactly one result per input transfer, in order: the
// progress code and, when a frame completes a write, the write request.
// An input transfer is captured in an input register; the decoder then
// evaluates it against the frame state and the result is loaded into the
// output register once that register is free or its result is taken.
// Throughput is one item per cycle while result_ready stays high, set by the
// single decode stage; both registers advance together, so an item is taken
// while the previous result is being delivered.
// When the receiver holds result_ready low, the output register holds its
// result, the input register fills, and item_ready drops until a result
// transfer frees a slot.
// Synchronous reset empties both registers and returns the frame state to
// idle, waiting for a break.
// ----------------------------------------------------------------------------
module serial_memory_write_command_parser
  import smwp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    item_valid,
  output logic    item_ready,
  output result_t result,
  output logic    result_valid,
  input  logic    result_ready
);

  item_t   item_reg;
  logic    item_reg_valid;
  result_t decoded;
  logic    advance;

  assign advance    = item_reg_valid && (!result_valid || result_ready);
  assign item_ready = !item_reg_valid || advance;

  smwp_decoder u_decoder (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item_reg),
    .result (decoded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_reg_valid <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (item_ready) begin
        item_reg_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_reg <= item;
    end
    if (advance) begin
      result <= decoded;
    end
  end

endmodule

/* rtl/smwp_checker.sv */
// ----------------------------------------------------------------------------
// smwp_checker
// Port-level checks for the serial memory write command parser.
// ----------------------------------------------------------------------------
module smwp_checker
  import smwp_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input item_t   item,
  input logic    item_valid,
  input logic    item_ready,
  input result_t result,
  input logic    result_valid,
  input logic    result_ready
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // no write means empty request fields
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.write_valid |->
      result.write_kind == KIND_TABLE && result.write_address == 16'd0 &&
      result.write_data == 8'd0)
    else $error("request fields set without write");

  // a write only completes a frame
  a_write_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.write_valid |-> result.progress == PROG_DONE)
    else $error("write with wrong progress");

  // table writes carry only an index
  a_table_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.write_valid && result.write_kind == KIND_TABLE |->
      result.write_address[15:8] == 8'd0)
    else $error("table write with high address bits");

  // nothing shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind serial_memory_write_command_parser smwp_checker u_smwp_checker (
  .clk          (clk),
  .rst          (rst),
  .item         (item),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result       (result),
  .result_valid (result_valid),
  .result_ready (result_ready)
);
